// ===== sv/cpsp_pkg.sv =====
// Shared constants, lookup tables, types and helpers for the cube slicer.
package cpsp_pkg;

    localparam int EPS_Q16  = 7;
    localparam int HALF_Q15 = 16384;

    // Configuration register indexes.
    localparam logic [1:0] REG_DIR_X = 2'd0;
    localparam logic [1:0] REG_DIR_Y = 2'd1;
    localparam logic [1:0] REG_DIR_Z = 2'd2;
    localparam logic [1:0] REG_COUNT = 2'd3;

    // Sign pattern of each cube corner: bit0 = x positive, bit1 = y, bit2 = z.
    localparam logic [2:0] CORNER_SIGN [8] = '{3'd0, 3'd1, 3'd3, 3'd2,
                                               3'd4, 3'd5, 3'd7, 3'd6};

    // End corners of the 12 cube edges.
    localparam logic [2:0] EDGE_A [12] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1,
                                           3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7};
    localparam logic [2:0] EDGE_B [12] = '{3'd1, 3'd2, 3'd3, 3'd0, 3'd4, 3'd5,
                                           3'd6, 3'd7, 3'd5, 3'd6, 3'd7, 3'd4};

    // Edge visiting order for each front corner, 12 entries per corner.
    localparam logic [3:0] EDGE_ORDER [96] = '{
        4'd0, 4'd1, 4'd5, 4'd6,   4'd4, 4'd8, 4'd11, 4'd9,  4'd3, 4'd7, 4'd2, 4'd10,
        4'd0, 4'd4, 4'd3, 4'd11,  4'd1, 4'd2, 4'd6, 4'd7,   4'd5, 4'd9, 4'd8, 4'd10,
        4'd1, 4'd5, 4'd0, 4'd8,   4'd2, 4'd3, 4'd7, 4'd4,   4'd6, 4'd10, 4'd9, 4'd11,
        4'd7, 4'd11, 4'd10, 4'd8, 4'd2, 4'd6, 4'd1, 4'd9,   4'd3, 4'd0, 4'd4, 4'd5,
        4'd8, 4'd5, 4'd9, 4'd1,   4'd11, 4'd10, 4'd7, 4'd6, 4'd4, 4'd3, 4'd0, 4'd2,
        4'd9, 4'd6, 4'd10, 4'd2,  4'd8, 4'd11, 4'd4, 4'd7,  4'd5, 4'd0, 4'd1, 4'd3,
        4'd9, 4'd8, 4'd5, 4'd4,   4'd6, 4'd1, 4'd2, 4'd0,   4'd10, 4'd7, 4'd11, 4'd3,
        4'd10, 4'd9, 4'd6, 4'd5,  4'd7, 4'd2, 4'd3, 4'd1,   4'd11, 4'd4, 4'd8, 4'd0};

    // Polygon corner used by each of the 12 triangle fan vertices.
    localparam logic [2:0] FAN_ORDER [12] = '{3'd0, 3'd1, 3'd2, 3'd0, 3'd2, 3'd3,
                                              3'd0, 3'd3, 3'd4, 3'd0, 3'd4, 3'd5};

    // Head of the slice queue as seen by the back end.
    typedef struct packed {
        logic       valid;
        logic [8:0] idx;
    } t_queue_head;

    // Setup status as seen by the back end.
    typedef struct packed {
        logic       done;
        logic [2:0] front;
    } t_setup_stat;

    // Axis along which an edge runs: 0 = x, 1 = y, 2 = z.
    function automatic logic [1:0] edge_axis(input logic [3:0] e);
        logic [2:0] diff;
        diff = CORNER_SIGN[EDGE_A[e]] ^ CORNER_SIGN[EDGE_B[e]];
        case (diff)
            3'd1:    edge_axis = 2'd0;
            3'd2:    edge_axis = 2'd1;
            default: edge_axis = 2'd2;
        endcase
    endfunction

    // Projected distance of a corner onto the plane normal, units of 2^-15.
    function automatic logic signed [17:0] corner_dist(input logic [2:0] c,
                                                       input logic signed [15:0] dx,
                                                       input logic signed [15:0] dy,
                                                       input logic signed [15:0] dz);
        logic [2:0]         sg;
        logic signed [17:0] ex, ey, ez;
        sg = CORNER_SIGN[c];
        ex = 18'(dx);
        ey = 18'(dy);
        ez = 18'(dz);
        corner_dist = (sg[0] ? ex : -ex) + (sg[1] ? ey : -ey) + (sg[2] ? ez : -ez);
    endfunction

endpackage

// ===== sv/cube_plane_slice_polygon.sv =====
// Top level of the cube slicer: configuration registers, front, setup and back.
// A slice's first vertex reaches the ports once the back end has swept its edges and selected
// its corners, and after the setup pass as well when that runs after reset or a config write.
// The back end takes a new slice only when it is through with the edge sweep and the emit of
// the last one; up to two slices queue ahead of it, and busy stops commands while both are held.
// Reset is synchronous, active low, restores register defaults; the receiver cannot stall.
module cube_plane_slice_polygon import cpsp_pkg::*; #(
    parameter int MAX_SLICES  = 512,
    parameter int PARAM_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_start,
    output logic               busy,
    input  logic [8:0]         i_slice_index,
    output logic               o_valid,
    output logic signed [15:0] o_vert_x,
    output logic signed [15:0] o_vert_y,
    output logic signed [15:0] o_vert_z,
    output logic               o_last_vertex
);

    localparam int NW = $clog2(MAX_SLICES + 1);

    logic signed [15:0]          r_dir_x, r_dir_y, r_dir_z;
    logic [9:0]                  r_count;
    logic [NW-1:0]               eff_count;
    t_queue_head                 head;
    t_setup_stat                 stat;
    logic                        pop, go;
    logic [3:0]                  rd_idx;
    logic signed [PARAM_WIDTH-1:0] start_p, step_p;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_x <= 16'sd0;
            r_dir_y <= 16'sd32767;
            r_dir_z <= 16'sd0;
            r_count <= 10'd500;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DIR_X: r_dir_x <= i_cfg_data;
                REG_DIR_Y: r_dir_y <= i_cfg_data;
                REG_DIR_Z: r_dir_z <= i_cfg_data;
                REG_COUNT: r_count <= i_cfg_data[9:0];
                default:   r_count <= r_count;
            endcase
        end
    end

    // Slice count clamped to the supported range.
    always_comb begin
        if (r_count < 10'd3) begin
            eff_count = NW'(3);
        end else if (32'(r_count) > 32'(MAX_SLICES)) begin
            eff_count = NW'(MAX_SLICES);
        end else begin
            eff_count = NW'(r_count);
        end
    end

    cpsp_front #(.NW(NW)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_slice_index (i_slice_index),
        .i_count       (eff_count),
        .i_pop         (pop),
        .o_busy        (busy),
        .o_head        (head)
    );

    cpsp_setup #(.PW(PARAM_WIDTH), .NW(NW)) u_setup (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clr    (i_cfg_we),
        .i_go     (go),
        .i_dir_x  (r_dir_x),
        .i_dir_y  (r_dir_y),
        .i_dir_z  (r_dir_z),
        .i_count  (eff_count),
        .i_rd_idx (rd_idx),
        .o_start  (start_p),
        .o_step   (step_p),
        .o_stat   (stat)
    );

    cpsp_back #(.PW(PARAM_WIDTH)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .i_stat        (stat),
        .o_go          (go),
        .o_rd_idx      (rd_idx),
        .i_start       (start_p),
        .i_step        (step_p),
        .o_valid       (o_valid),
        .o_vert_x      (o_vert_x),
        .o_vert_y      (o_vert_y),
        .o_vert_z      (o_vert_z),
        .o_last_vertex (o_last_vertex)
    );

endmodule

// ===== sv/cpsp_front.sv =====
// Front end: takes slice commands, drops out-of-range slices, queues the rest while there is room.
module cpsp_front import cpsp_pkg::*; #(
    parameter int NW = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [8:0]        i_slice_index,
    input  logic [NW-1:0]     i_count,
    input  logic              i_pop,
    output logic              o_busy,
    output t_queue_head       o_head
);

    logic [8:0] r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       in_range, push;

    // A slice at or beyond the effective count produces nothing; drop it here.
    assign in_range = (NW + 9)'(i_slice_index) < (NW + 9)'(i_count);
    assign o_busy   = (r_cnt == 2'd2);
    assign push     = i_start && !o_busy && in_range;

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.idx   = r_q[r_rp];

    // Two-entry queue between the command side and the back end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_slice_index;
        end
    end

endmodule

// ===== sv/cpsp_setup.sv =====
// Setup pass: corner projection, front corner search and per-edge division.
module cpsp_setup import cpsp_pkg::*; #(
    parameter int PW = 32,
    parameter int NW = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clr,
    input  logic                 i_go,
    input  logic signed [15:0]   i_dir_x,
    input  logic signed [15:0]   i_dir_y,
    input  logic signed [15:0]   i_dir_z,
    input  logic [NW-1:0]        i_count,
    input  logic [3:0]           i_rd_idx,
    output logic signed [PW-1:0] o_start,
    output logic signed [PW-1:0] o_step,
    output t_setup_stat          o_stat
);

    localparam int FRAC = PW - 16;
    localparam int DVW  = PW + 4;
    localparam int DSW  = NW + 17;
    localparam int CNTW = $clog2(DVW + 1);
    localparam logic [DVW-1:0] HI_MAG = DVW'({(PW-1){1'b1}});
    localparam logic [DVW-1:0] LO_MAG = DVW'({1'b1, {(PW-1){1'b0}}});
    localparam logic signed [PW-1:0] NEG_ONE = {{16{1'b1}}, {FRAC{1'b0}}};
    localparam logic signed [PW-1:0] HI_VAL  = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] LO_VAL  = {1'b1, {(PW-1){1'b0}}};

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CORN = 3'd1;
    localparam logic [2:0] S_EDGE = 3'd2;
    localparam logic [2:0] S_DIVA = 3'd3;
    localparam logic [2:0] S_WRA  = 3'd4;
    localparam logic [2:0] S_DIVB = 3'd5;
    localparam logic [2:0] S_WRB  = 3'd6;

    logic [2:0]            r_state;
    logic [2:0]            r_c;
    logic signed [17:0]    r_mx, r_mn;
    logic [2:0]            r_fc;
    logic [3:0]            r_i;
    logic                  r_done;
    logic [DVW-1:0]        r_quo;
    logic [DSW:0]          r_rem;
    logic [DSW-1:0]        r_dvs, r_dvs_b;
    logic [CNTW-1:0]       r_cnt;
    logic                  r_neg, r_neg_b;
    logic signed [PW-1:0]  r_start [12];
    logic signed [PW-1:0]  r_step  [12];

    logic signed [17:0]    dist_c;
    logic [3:0]            e;
    logic [1:0]            ax;
    logic signed [16:0]    dax, den;
    logic [15:0]           dabs;
    logic signed [19:0]    num, span;
    logic [19:0]           nabs;
    logic [NW+15:0]        nprod;
    logic [DSW:0]          sh;
    logic                  ge;
    logic [DSW:0]          rem_n;
    logic [DVW-1:0]        quo_n;

    function automatic logic signed [PW-1:0] sat_q(input logic [DVW-1:0] q,
                                                   input logic neg);
        logic [DVW-1:0] nq;
        nq = -q;
        if (neg) begin
            sat_q = (q >= LO_MAG) ? LO_VAL : nq[PW-1:0];
        end else begin
            sat_q = (q > HI_MAG) ? HI_VAL : q[PW-1:0];
        end
    endfunction

    assign o_start     = r_start[i_rd_idx];
    assign o_step      = r_step[i_rd_idx];
    assign o_stat.done  = r_done;
    assign o_stat.front = r_fc;

    // Corner projection for the corner sweep.
    assign dist_c = corner_dist(r_c, i_dir_x, i_dir_y, i_dir_z);

    // Edge geometry for the current table slot.
    always_comb begin
        e   = EDGE_ORDER[7'(r_fc) * 7'd12 + 7'(r_i)];
        ax  = edge_axis(e);
        case (ax)
            2'd0:    dax = 17'(i_dir_x);
            2'd1:    dax = 17'(i_dir_y);
            default: dax = 17'(i_dir_z);
        endcase
        den   = CORNER_SIGN[EDGE_B[e]][ax] ? dax : -dax;
        dabs  = den[16] ? 16'(-den) : 16'(den);
        num   = 20'(r_mn) - 20'sd7 - 20'(corner_dist(EDGE_A[e], i_dir_x, i_dir_y, i_dir_z));
        nabs  = num[19] ? 20'(-num) : 20'(num);
        span  = 20'(r_mx) - 20'(r_mn) + 20'sd14;
        nprod = i_count * dabs;
    end

    // One quotient bit per cycle, restoring division on magnitudes.
    always_comb begin
        sh    = {r_rem[DSW-1:0], r_quo[DVW-1]};
        ge    = (sh >= {1'b0, r_dvs});
        rem_n = ge ? (sh - {1'b0, r_dvs}) : sh;
        quo_n = {r_quo[DVW-2:0], ge};
    end

    // Control of the setup sequence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_fc    <= 3'd0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_clr) begin
                        r_done <= 1'b0;
                    end else if (i_go && !r_done) begin
                        r_c     <= 3'd0;
                        r_state <= S_CORN;
                    end
                end
                S_CORN: begin
                    if (r_c == 3'd0) begin
                        r_mx <= dist_c;
                        r_mn <= dist_c;
                        r_fc <= 3'd0;
                    end else begin
                        if (dist_c > r_mx) begin
                            r_mx <= dist_c;
                            r_fc <= r_c;
                        end
                        if (dist_c < r_mn) begin
                            r_mn <= dist_c;
                        end
                    end
                    r_c <= r_c + 3'd1;
                    if (r_c == 3'd7) begin
                        r_i     <= 4'd0;
                        r_state <= S_EDGE;
                    end
                end
                S_EDGE: begin
                    if (den == 17'sd0) begin
                        // Edge parallel to the planes is never hit.
                        r_start[r_i] <= NEG_ONE;
                        r_step[r_i]  <= '0;
                        r_i <= r_i + 4'd1;
                        if (r_i == 4'd11) begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_quo   <= DVW'({nabs[18:0], {FRAC{1'b0}}});
                        r_rem   <= '0;
                        r_dvs   <= DSW'({dabs, 1'b0});
                        r_dvs_b <= {nprod, 1'b0};
                        r_neg   <= num[19] ^ den[16];
                        r_neg_b <= den[16];
                        r_cnt   <= '0;
                        r_state <= S_DIVA;
                    end
                end
                S_DIVA, S_DIVB: begin
                    r_quo <= quo_n;
                    r_rem <= rem_n;
                    r_cnt <= r_cnt + CNTW'(1);
                    if (r_cnt == CNTW'(DVW - 1)) begin
                        r_state <= (r_state == S_DIVA) ? S_WRA : S_WRB;
                    end
                end
                S_WRA: begin
                    r_start[r_i] <= sat_q(r_quo, r_neg);
                    r_quo   <= DVW'({span[18:0], {FRAC{1'b0}}});
                    r_rem   <= '0;
                    r_dvs   <= r_dvs_b;
                    r_neg   <= r_neg_b;
                    r_cnt   <= '0;
                    r_state <= S_DIVB;
                end
                S_WRB: begin
                    r_step[r_i] <= sat_q(r_quo, r_neg);
                    r_i <= r_i + 4'd1;
                    if (r_i == 4'd11) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_EDGE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/cpsp_back.sv =====
// Back end: evaluates edge parameters for one slice and emits the fan.
module cpsp_back import cpsp_pkg::*; #(
    parameter int PW = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_queue_head          i_head,
    output logic                 o_pop,
    input  t_setup_stat          i_stat,
    output logic                 o_go,
    output logic [3:0]           o_rd_idx,
    input  logic signed [PW-1:0] i_start,
    input  logic signed [PW-1:0] i_step,
    output logic                 o_valid,
    output logic signed [15:0]   o_vert_x,
    output logic signed [15:0]   o_vert_y,
    output logic signed [15:0]   o_vert_z,
    output logic                 o_last_vertex
);

    localparam int FRAC = PW - 16;
    localparam int CW   = FRAC + 3;
    localparam int XW   = PW + 11;
    localparam logic signed [XW-1:0] P_ONE   = XW'(1) << FRAC;
    localparam logic signed [XW-1:0] P_TWO   = XW'(1) << (FRAC + 1);
    localparam logic signed [XW-1:0] P_NTWO  = -P_TWO;
    localparam logic [CW+14:0]       BIAS    = (CW + 15)'({FRAC{1'b1}});

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_WAIT  = 3'd1;
    localparam logic [2:0] B_PARAM = 3'd2;
    localparam logic [2:0] B_SEL   = 3'd3;
    localparam logic [2:0] B_EMIT  = 3'd4;

    logic [2:0]            r_state;
    logic [3:0]            r_k;
    logic [8:0]            r_idx;
    logic [11:0]           r_hit;
    logic signed [CW-1:0]  r_pc [12];
    logic [3:0]            r_slot [6];
    logic                  r_valid, r_last;
    logic signed [15:0]    r_vx, r_vy, r_vz;

    logic signed [XW-1:0]  p;
    logic [3:0]            n_slot [6];
    logic [3:0]            s;
    logic [3:0]            e;
    logic [1:0]            ax;
    logic [2:0]            ca, cb;
    logic signed [CW-1:0]  pv;
    logic signed [CW+14:0] pw;
    logic signed [CW+14:0] off_w;
    logic signed [18:0]    off;
    logic signed [18:0]    co [3];
    logic signed [15:0]    cs [3];

    assign o_go     = (r_state == B_WAIT);
    assign o_pop    = (r_state == B_IDLE) && i_head.valid;
    assign o_rd_idx = r_k;

    // Parameter of the slice on the current edge slot.
    assign p = XW'(i_start) + i_step * $signed({1'b0, r_idx});

    // Polygon corner choice by fixed edge priority.
    always_comb begin
        n_slot[0] = r_hit[0] ? 4'd0 : (r_hit[1] ? 4'd1 : 4'd3);
        n_slot[1] = r_hit[2] ? 4'd2 : (r_hit[0] ? 4'd0 : (r_hit[1] ? 4'd1 : 4'd3));
        n_slot[2] = r_hit[4] ? 4'd4 : (r_hit[5] ? 4'd5 : 4'd7);
        n_slot[3] = r_hit[6] ? 4'd6 : (r_hit[4] ? 4'd4 : (r_hit[5] ? 4'd5 : 4'd7));
        n_slot[4] = r_hit[8] ? 4'd8 : (r_hit[9] ? 4'd9 : 4'd11);
        n_slot[5] = r_hit[10] ? 4'd10 : (r_hit[8] ? 4'd8 : (r_hit[9] ? 4'd9 : 4'd11));
    end

    // Vertex position for the current fan vertex.
    always_comb begin
        s     = r_slot[FAN_ORDER[r_k]];
        e     = EDGE_ORDER[7'(i_stat.front) * 7'd12 + 7'(s)];
        ax    = edge_axis(e);
        ca    = CORNER_SIGN[EDGE_A[e]];
        cb    = CORNER_SIGN[EDGE_B[e]];
        pv    = r_pc[s];
        pw    = {pv, 15'b0};
        off_w = (pw + (pv[CW-1] ? $signed(BIAS) : $signed((CW + 15)'(0)))) >>> FRAC;
        off   = off_w[18:0];
        for (int k = 0; k < 3; k++) begin
            co[k] = ca[k] ? 19'sd16384 : -19'sd16384;
            if (2'(k) == ax) begin
                co[k] = co[k] + (cb[k] ? off : -off);
            end
            if (co[k] > 19'sd32767) begin
                cs[k] = 16'sd32767;
            end else if (co[k] < -19'sd32768) begin
                cs[k] = -16'sd32768;
            end else begin
                cs[k] = co[k][15:0];
            end
        end
    end

    // Sequencer: wait for setup, sweep the edge slots, select corners, emit the fan for a slice that hits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            r_last  <= 1'b0;
            case (r_state)
                B_IDLE: begin
                    if (i_head.valid) begin
                        r_idx   <= i_head.idx;
                        r_state <= B_WAIT;
                    end
                end
                B_WAIT: begin
                    if (i_stat.done) begin
                        r_k     <= 4'd0;
                        r_state <= B_PARAM;
                    end
                end
                B_PARAM: begin
                    r_hit[r_k] <= (p >= 0) && (p < P_ONE);
                    if (p > P_TWO) begin
                        r_pc[r_k] <= P_TWO[CW-1:0];
                    end else if (p < P_NTWO) begin
                        r_pc[r_k] <= P_NTWO[CW-1:0];
                    end else begin
                        r_pc[r_k] <= p[CW-1:0];
                    end
                    r_k <= r_k + 4'd1;
                    if (r_k == 4'd11) begin
                        r_state <= B_SEL;
                    end
                end
                B_SEL: begin
                    for (int i = 0; i < 6; i++) begin
                        r_slot[i] <= n_slot[i];
                    end
                    r_k     <= 4'd0;
                    // A slice that touches none of edge slots 0, 1 and 3 misses the cube.
                    r_state <= (r_hit[0] || r_hit[1] || r_hit[3]) ? B_EMIT : B_IDLE;
                end
                B_EMIT: begin
                    r_valid <= 1'b1;
                    r_vx    <= cs[0];
                    r_vy    <= cs[1];
                    r_vz    <= cs[2];
                    r_k     <= r_k + 4'd1;
                    if (r_k == 4'd11) begin
                        r_last  <= 1'b1;
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_valid       = r_valid;
    assign o_last_vertex = r_last;
    assign o_vert_x      = r_vx;
    assign o_vert_y      = r_vy;
    assign o_vert_z      = r_vz;

endmodule

// ===== sv/cpsp_checker.sv =====
// Port-level checks of the cube slicer's result stream, bound to the top level.
module cpsp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic busy,
    input logic o_valid,
    input logic o_last_vertex
);

    // The end-of-fan flag only marks a real vertex.
    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_vertex |-> o_valid) else $error("last vertex without valid");

    // A fan runs out without gaps until the vertex that carries the end-of-fan flag.
    a_fan_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_vertex |=> o_valid) else $error("gap inside a fan");

    // Fans of two slices never abut.
    a_fan_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_vertex |=> !o_valid) else $error("fan follows fan at once");

    // Reset leaves no result and an open command port.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !busy) else $error("state after reset");

endmodule

bind cube_plane_slice_polygon cpsp_checker u_cpsp_checker (.*);
